>>> sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, codes and constants of the packet spacing burst shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    localparam int unsigned TIME_W      = 64;
    localparam int unsigned SPACING_W   = 32;
    localparam int unsigned BURST_W     = 16;
    localparam int unsigned PEND_W      = 11;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    // Outstanding delayed sends allowed before arrivals are refused
    localparam logic [PEND_W-1:0] MAX_PENDING = PEND_W'(1024);
    localparam logic [BURST_W-1:0] BURST_MAX  = {BURST_W{1'b1}};

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_FIRE   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ACT_SEND     = 2'd0,
        ACT_DELAYED  = 2'd1,
        ACT_RELEASED = 2'd2,
        ACT_ERROR    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACING = 1'b0,
        CFG_BURST   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SPACING_W-1:0] spacing;
        logic [BURST_W-1:0]   allowance;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  last_send;
        logic [BURST_W-1:0] burst;
        logic [PEND_W-1:0]  pending;
        logic [TIME_W-1:0]  tail_time;
        logic               limited;
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [TIME_W-1:0]  send_time;
        logic [PEND_W-1:0]  pending_count;
        logic               limited;
    } t_result;

endpackage

`default_nettype wire

>>> sv/pss_in_if.sv
// ----------------------------------------------------------------------------
// pss_in_if
// Input channel: packet arrivals and delayed-send firings with a timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface pss_in_if;
    import pss_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, output op, output time_now, input ready);
    modport sink   (input valid, input op, input time_now, output ready);
endinterface

`default_nettype wire

>>> sv/pss_out_if.sv
// ----------------------------------------------------------------------------
// pss_out_if
// Output channel: one shaping decision per input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pss_out_if;
    import pss_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [TIME_W-1:0] send_time;
    logic [PEND_W-1:0] pending_count;
    logic              limited;

    modport source (output valid, output action, output send_time,
                    output pending_count, output limited, input ready);
    modport sink   (input valid, input action, input send_time,
                    input pending_count, input limited, output ready);
endinterface

`default_nettype wire

>>> sv/pss_cfg.sv
// ----------------------------------------------------------------------------
// pss_cfg
// Configuration register file: spacing and burst allowance.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pss_pkg::t_cfg                       o_cfg
);
    import pss_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPACING: r_cfg.spacing   <= i_cfg_wdata[SPACING_W-1:0];
                CFG_BURST:   r_cfg.allowance <= i_cfg_wdata[BURST_W-1:0];
                default:     r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/pss_step.sv
// ----------------------------------------------------------------------------
// pss_step
// Shaping decision for one item: next state and result from current state.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_step (
    input  wire pss_pkg::t_cfg              i_cfg,
    input  wire pss_pkg::t_state            i_state,
    input  wire logic                       i_op,
    input  wire logic [pss_pkg::TIME_W-1:0] i_time_now,
    output pss_pkg::t_state                 o_state,
    output pss_pkg::t_result                o_result
);
    import pss_pkg::*;

    logic [TIME_W:0]    gap;
    logic               close;
    logic [BURST_W-1:0] burst_inc;
    logic [TIME_W-1:0]  spacing_ext;
    logic [TIME_W-1:0]  sched_from_send;
    logic [TIME_W-1:0]  sched_from_delayed;
    logic [PEND_W-1:0]  pending_dec;

    // Full-precision gap: a borrow means the last send lies in the future
    assign gap          = {1'b0, i_time_now} - {1'b0, i_state.last_send};
    assign spacing_ext  = {{(TIME_W-SPACING_W){1'b0}}, i_cfg.spacing};
    assign close        = (i_state.last_send != '0)
                       && (gap[TIME_W] || (gap[TIME_W-1:0] < spacing_ext));
    assign burst_inc    = (i_state.burst == BURST_MAX) ? i_state.burst
                                                       : i_state.burst + 1'b1;
    assign sched_from_send    = i_state.last_send + spacing_ext;
    assign sched_from_delayed = i_state.tail_time + spacing_ext;
    assign pending_dec        = i_state.pending - 1'b1;

    always_comb begin
        t_state  nxt;
        t_action act;
        logic [TIME_W-1:0] when;

        nxt  = i_state;
        act  = ACT_SEND;
        when = i_time_now;

        if (t_op'(i_op) == OP_FIRE) begin
            if (i_state.pending == '0) begin
                act = ACT_ERROR;
            end else begin
                act         = ACT_RELEASED;
                nxt.pending = pending_dec;
                if (pending_dec == '0) begin
                    nxt.burst     = '0;
                    nxt.limited   = 1'b0;
                    nxt.last_send = i_time_now;
                end
            end
        end else if (i_cfg.spacing == '0) begin
            act = ACT_SEND;
        end else if (i_state.pending != '0) begin
            if (i_state.pending >= MAX_PENDING) begin
                act = ACT_ERROR;
            end else begin
                act           = ACT_DELAYED;
                nxt.tail_time = sched_from_delayed;
                nxt.pending   = i_state.pending + 1'b1;
                when          = sched_from_delayed;
            end
        end else if (close && (burst_inc > i_cfg.allowance)) begin
            act           = ACT_DELAYED;
            nxt.burst     = burst_inc;
            nxt.limited   = 1'b1;
            nxt.tail_time = sched_from_send;
            nxt.pending   = i_state.pending + 1'b1;
            when          = sched_from_send;
        end else begin
            act           = ACT_SEND;
            nxt.burst     = close ? burst_inc : '0;
            nxt.last_send = i_time_now;
        end

        o_state                = nxt;
        o_result.action        = act;
        o_result.send_time     = when;
        o_result.pending_count = nxt.pending;
        o_result.limited       = nxt.limited;
    end

endmodule

`default_nettype wire

>>> sv/packet_spacing_burst_shaper_core.sv
// ----------------------------------------------------------------------------
// packet_spacing_burst_shaper_core
// Per-destination output shaper: sends, delays or releases packets so that
// sends keep a minimum spacing once a burst allowance is used up.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   --------  ----  ---------------  -------------------------------------------
//   i_in      in    valid / ready    op, time_now
//   o_out     out   valid / ready    action, send_time, pending_count, limited
//   i_cfg_*   in    write enable     index (0 spacing, 1 burst allowance), data
//
// Throughput: one transfer per clock while the result is not stalled; an input
// transfer passes the input register, then the result register.
// The shaper state closes a feedback loop through the 64-bit gap subtract and
// spacing compare, which sets the clock period of this block.
// Reset (i_rst_n low, synchronous) clears the shaper state, the configuration
// and both valid flags. A stalled result holds the input register and the
// state; i_in.ready drops only when both registers are full.
//
`default_nettype none

module packet_spacing_burst_shaper_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    pss_in_if.sink                              i_in,
    pss_out_if.source                           o_out
);
    import pss_pkg::*;

    t_cfg    cfg;
    t_state  n_state;
    t_result n_result;

    logic              r_in_valid;
    logic              r_in_op;
    logic [TIME_W-1:0] r_in_time;
    t_state            r_state;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              in_xfer;

    pss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pss_step u_step (
        .i_cfg      (cfg),
        .i_state    (r_state),
        .i_op       (r_in_op),
        .i_time_now (r_in_time),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // Advance the pipe whenever the result register is free or being drained
    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;

    // Input register: capture on every transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_xfer) begin
            r_in_op   <= i_in.op;
            r_in_time <= i_in.time_now;
        end
    end

    // State and result register: commit one decision per advancing item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_out.action;
    assign o_out.send_time     = r_out.send_time;
    assign o_out.pending_count = r_out.pending_count;
    assign o_out.limited       = r_out.limited;

`ifndef ASSERT_OFF
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending <= MAX_PENDING)
        else $error("pending count above limit");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> $stable(r_state))
        else $error("state changed while result stalled");

    a_delay_is_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_DELAYED)
            |-> (r_out.limited && r_out.pending_count != '0))
        else $error("delayed result without limited state");

    a_drain_clears_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_RELEASED && r_out.pending_count == '0)
            |-> !r_out.limited)
        else $error("limited flag survived final release");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_spacing_burst_shaper_core. A driver pulls
// arrivals and delayed-send firings from a queue, and an in-bench shaper model
// predicts each decision at the input transfer. A monitor compares every
// output transfer with the oldest prediction, field by field. Phases change
// spacing and burst allowance while the core is idle: reset values, directed
// corner cases, a run of queued delayed packets and random traffic with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_LIMIT  = 40;
    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    typedef struct {
        t_op               op;
        logic [TIME_W-1:0] time_now;
    } t_shaper_op;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    pss_in_if  in_ch ();
    pss_out_if out_ch ();

    packet_spacing_burst_shaper_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending stimulus, expected decisions and bookkeeping
    t_shaper_op shaper_ops_q[$];
    t_result    decision_q[$];
    int unsigned ops_queued = 0;
    int unsigned ops_taken  = 0;
    int unsigned mismatch_count = 0;
    bit          idle_enabled = 1'b1;
    logic [TIME_W-1:0] stim_clock = '0;

    // Shaper model: configuration copy and per-destination state
    logic [SPACING_W-1:0] cfg_spacing   = '0;
    logic [BURST_W-1:0]   cfg_allowance = '0;
    logic [TIME_W-1:0]    mdl_last_send = '0;
    logic [BURST_W-1:0]   mdl_burst     = '0;
    logic [PEND_W-1:0]    mdl_pending   = '0;
    logic [TIME_W-1:0]    mdl_tail_time = '0;
    logic                 mdl_limited   = 1'b0;

    // ------------------------------------------------------------------------
    // Predict the decision for one accepted transfer and advance the model.
    // ------------------------------------------------------------------------
    function automatic void predict_decision(input logic op, input logic [TIME_W-1:0] now);
        t_result             want;
        logic [TIME_W-1:0]   spacing64;
        logic                too_close;
        spacing64      = {{(TIME_W-SPACING_W){1'b0}}, cfg_spacing};
        want.send_time = now;
        if (op == OP_FIRE) begin
            // A firing with nothing outstanding is an error and changes nothing
            if (mdl_pending == '0) begin
                want.action = ACT_ERROR;
            end else begin
                mdl_pending = mdl_pending - 1'b1;
                if (mdl_pending == '0) begin
                    mdl_burst     = '0;
                    mdl_limited   = 1'b0;
                    mdl_last_send = now;
                end
                want.action = ACT_RELEASED;
            end
        end else if (cfg_spacing == '0) begin
            // Shaping off: send at once, state untouched
            want.action = ACT_SEND;
        end else if (mdl_pending != '0) begin
            // Queue behind the last delayed packet unless the queue is full
            if (mdl_pending >= MAX_PENDING) begin
                want.action = ACT_ERROR;
            end else begin
                mdl_tail_time  = mdl_tail_time + spacing64;
                mdl_pending    = mdl_pending + 1'b1;
                want.action    = ACT_DELAYED;
                want.send_time = mdl_tail_time;
            end
        end else begin
            // Full-precision gap test; a last send later than now is too close
            too_close = (mdl_last_send != '0) &&
                        ((now < mdl_last_send) || ((now - mdl_last_send) < spacing64));
            if (too_close) begin
                if (mdl_burst != BURST_MAX) mdl_burst = mdl_burst + 1'b1;
            end else begin
                mdl_burst = '0;
            end
            if (too_close && (mdl_burst > cfg_allowance)) begin
                mdl_limited    = 1'b1;
                mdl_tail_time  = mdl_last_send + spacing64;
                mdl_pending    = mdl_pending + 1'b1;
                want.action    = ACT_DELAYED;
                want.send_time = mdl_tail_time;
            end else begin
                mdl_last_send = now;
                want.action   = ACT_SEND;
            end
        end
        want.pending_count = mdl_pending;
        want.limited       = mdl_limited;
        decision_q.push_back(want);
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_idle(input bit enabled);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict on each input transfer, then load the next item or idle.
    // ------------------------------------------------------------------------
    int unsigned src_gap = 0;

    always @(posedge i_clk) begin
        t_shaper_op next_op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_decision(in_ch.op, in_ch.time_now);
                ops_taken++;
            end
            // Advance only when the slot is free or the current item just moved
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (shaper_ops_q.size() != 0) begin
                    next_op = shaper_ops_q.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.op       <= next_op.op;
                    in_ch.time_now <= next_op.time_now;
                    src_gap = pick_idle(idle_enabled);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each output transfer, then stall the sink at random.
    // ------------------------------------------------------------------------
    int unsigned sink_stall = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (decision_q.size() == 0) begin
                    report_mismatch("unexpected result, send_time", out_ch.send_time, '0);
                end else begin
                    want = decision_q.pop_front();
                    if (out_ch.action !== want.action)
                        report_mismatch("action", TIME_W'(out_ch.action),
                                        TIME_W'(want.action));
                    if (out_ch.send_time !== want.send_time)
                        report_mismatch("send_time", out_ch.send_time, want.send_time);
                    if (out_ch.pending_count !== want.pending_count)
                        report_mismatch("pending_count", TIME_W'(out_ch.pending_count),
                                        TIME_W'(want.pending_count));
                    if (out_ch.limited !== want.limited)
                        report_mismatch("limited", TIME_W'(out_ch.limited),
                                        TIME_W'(want.limited));
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                sink_stall = pick_idle(idle_enabled);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(input t_op op, input logic [TIME_W-1:0] now);
        t_shaper_op item;
        item.op       = op;
        item.time_now = now;
        shaper_ops_q.push_back(item);
        ops_queued++;
    endtask

    // Hold until every queued item has moved and every decision has arrived
    task automatic wait_drained();
        while (ops_taken != ops_queued || decision_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_SPACING) cfg_spacing = data[SPACING_W-1:0];
        else cfg_allowance = data[BURST_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drain, then reprogram both registers for the next phase
    task automatic start_phase(input logic [SPACING_W-1:0] spacing,
                               input logic [BURST_W-1:0] allowance);
        wait_drained();
        cfg_write(CFG_SPACING, CFG_DATA_W'(spacing));
        cfg_write(CFG_BURST, CFG_DATA_W'(allowance));
    endtask

    // Random traffic: mostly a forward-moving clock with gaps around one
    // spacing, plus backward steps, random timestamps and the extremes.
    task automatic queue_random(input int unsigned count);
        logic [TIME_W-1:0] span;
        int unsigned       roll;
        t_op               op;
        span = {31'b0, cfg_spacing, 1'b1};
        for (int unsigned n = 0; n < count; n++) begin
            op   = ($urandom_range(0, 99) < 40) ? OP_FIRE : OP_ARRIVE;
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                stim_clock = stim_clock + ({$urandom, $urandom} % span);
                queue_op(op, stim_clock);
            end else if (roll < 85) begin
                queue_op(op, stim_clock - ({$urandom, $urandom} % span));
            end else if (roll < 95) begin
                queue_op(op, {$urandom, $urandom});
            end else begin
                queue_op(op, $urandom_range(0, 1) ? TIME_TOP : '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_ARRIVE;
        in_ch.time_now = '0;
        out_ch.ready   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: shaping off, stray firing is an error
        queue_op(OP_ARRIVE, '0);
        queue_op(OP_ARRIVE, TIME_TOP);
        queue_op(OP_FIRE, 64'd5);
        queue_op(OP_ARRIVE, 64'h5555_5555_AAAA_AAAA);

        // Burst allowance, queueing behind delayed packets, release and
        // restart, an arrival earlier than the last send
        start_phase(32'd10, 16'd1);
        queue_op(OP_ARRIVE, 64'd100);
        queue_op(OP_ARRIVE, 64'd105);
        queue_op(OP_ARRIVE, 64'd107);
        queue_op(OP_ARRIVE, 64'd108);
        queue_op(OP_FIRE, 64'd115);
        queue_op(OP_FIRE, 64'd125);
        queue_op(OP_ARRIVE, 64'd126);
        queue_op(OP_ARRIVE, 64'd300);
        queue_op(OP_ARRIVE, 64'd150);
        queue_op(OP_FIRE, 64'd151);
        queue_op(OP_ARRIVE, '0);
        queue_op(OP_FIRE, 64'd170);

        // Scheduled time wraps past the top of the time range
        start_phase({SPACING_W{1'b1}}, 16'd0);
        queue_op(OP_ARRIVE, TIME_TOP - 64'd5);
        queue_op(OP_ARRIVE, TIME_TOP);
        queue_op(OP_ARRIVE, TIME_TOP);
        queue_op(OP_FIRE, 64'd1);
        queue_op(OP_FIRE, 64'd2);
        queue_op(OP_FIRE, 64'd3);

        // Build a run of queued delayed packets, then drain it with one
        // stray firing at the end
        start_phase(32'd3, 16'd0);
        for (int unsigned k = 0; k < 40; k++)
            queue_op(OP_ARRIVE, 64'd1000 + k);
        for (int unsigned k = 0; k < 40; k++)
            queue_op(OP_FIRE, 64'd5000 + k);

        // Random traffic under several settings
        idle_enabled = 1'b1;
        stim_clock   = 64'h200_0000_0000;
        start_phase(32'($urandom_range(1, 20)), 16'($urandom_range(0, 3)));
        queue_random(150);
        start_phase('0, 16'($urandom_range(0, 4)));
        queue_random(120);
        start_phase({SPACING_W{1'b1}}, BURST_MAX);
        queue_random(150);
        start_phase(32'($urandom | 1), 16'($urandom));
        queue_random(150);
        idle_enabled = 1'b0;
        start_phase(32'd1, 16'd0);
        queue_random(150);
        idle_enabled = 1'b1;
        start_phase(32'($urandom_range(1, 1000)), 16'($urandom_range(0, 8)));
        queue_random(150);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/pss_pkg.sv
sv/pss_in_if.sv
sv/pss_out_if.sv
sv/pss_cfg.sv
sv/pss_step.sv
sv/packet_spacing_burst_shaper_core.sv
verif/testbench.sv
